// ===== hdl/cpa_pkg.sv =====
// cpa_pkg: shared types and codes of the contiguous page allocator
// transaction structs for both channels, page table entry, command codes
// no dependencies
package cpa_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RESERVE = 2'd1;
  localparam logic [1:0] CMD_FREE    = 2'd2;
  localparam logic [1:0] CMD_PURGE   = 2'd3;

  // status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // field widths
  localparam int START_W = 10;
  localparam int COUNT_W = 11;
  localparam int OWNER_W = 4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [START_W-1:0] start_page;
    logic [COUNT_W-1:0] page_count;
    logic [OWNER_W-1:0] owner;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [START_W-1:0] found_page;
    logic [COUNT_W-1:0] pages_changed;
  } out_t;

  // one page table entry
  typedef struct packed {
    logic               reserved;
    logic [OWNER_W-1:0] owner;
  } entry_t;

endpackage

// ===== hdl/cpa_table.sv =====
// cpa_table: page table memory with one write and one registered read port
// runs a clearing pass over every entry after reset
// depends on cpa_pkg
module cpa_table #(
  parameter int PAGES = 1024,
  localparam int AW = $clog2(PAGES)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [AW-1:0]   rd_addr,
  output cpa_pkg::entry_t rd_entry,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cpa_pkg::entry_t wr_entry,
  output logic            clr_busy
);

  cpa_pkg::entry_t mem [PAGES];
  cpa_pkg::entry_t rd_entry_r;
  logic            clr_busy_r;
  logic [AW-1:0]   clr_ptr_r;

  // clearing pass sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_ptr_r  <= '0;
    end else if (clr_busy_r) begin
      clr_ptr_r <= clr_ptr_r + 1'b1;
      if (clr_ptr_r == AW'(PAGES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_ptr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== hdl/contiguous_page_allocator_unit.sv =====
// contiguous_page_allocator_unit: first-fit page allocator top level
// sequencer that scans and writes the page table one entry per cycle
// depends on cpa_pkg and cpa_table
//
// Usage: one command transaction enters on in_* (valid/stall), exactly one
// result transaction leaves on out_*. Commands: allocate the lowest free run
// of page_count pages, reserve a range, free a range, free all of an owner.
// The block works on one command at a time; in_stall is high from the cycle
// after acceptance until the result has moved to the output register.
// Steps per command, all through the page table (one entry a cycle):
//   allocate:        first-fit scan of the table, then page_count writes
//   reserve / free:  page_count writes
//   free all owner:  scan of every entry, freeing the owner's pages
//   rejected:        no table access
// The next command is taken while a result still waits in the output
// register; a held out_stall keeps out_data steady and, once the next result
// is ready, holds the sequencer too.
// After reset the table is cleared in a pass over every entry, during which
// in_stall stays high.
module contiguous_page_allocator_unit #(
  parameter int PAGES  = 1024,
  parameter int OWNERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cpa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cpa_pkg::out_t out_data
);

  localparam int AW = $clog2(PAGES);
  localparam int CW = $clog2(PAGES + 1);
  localparam int WW = (CW > 12) ? CW : 12;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_PURGE,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [3:0]      owner_r, owner_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]   chk_ptr_r, chk_ptr_nxt;
  logic [CW-1:0]   run_r, run_nxt;
  logic [AW-1:0]   first_r, first_nxt;
  logic [AW-1:0]   wptr_r, wptr_nxt;
  logic [CW-1:0]   wleft_r, wleft_nxt;
  cpa_pkg::entry_t wentry_r, wentry_nxt;
  logic [CW-1:0]   freed_r, freed_nxt;
  cpa_pkg::out_t   res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  cpa_pkg::out_t   out_data_r, out_data_nxt;

  // table port
  logic [AW-1:0]   rd_addr;
  cpa_pkg::entry_t rd_entry;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  cpa_pkg::entry_t wr_entry;
  logic            clr_busy;

  // widened values for compares
  logic [WW-1:0] pages_w, in_cnt_w, in_start_w, in_end_w;
  logic [WW-1:0] rd_ptr_w, run_w, count_w, freed_w, run_first_w;
  logic [AW-1:0] run_first;
  logic          owner_ok, rd_more, out_free;

  cpa_table #(
    .PAGES (PAGES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .clr_busy (clr_busy)
  );

  assign pages_w     = WW'(PAGES);
  assign in_cnt_w    = WW'(in_data.page_count);
  assign in_start_w  = WW'(in_data.start_page);
  assign in_end_w    = in_start_w + in_cnt_w;
  assign rd_ptr_w    = WW'(rd_ptr_r);
  assign run_w       = WW'(run_r);
  assign count_w     = WW'(count_r);
  assign freed_w     = WW'(freed_r);
  assign run_first   = (run_r == '0) ? chk_ptr_r : first_r;
  assign run_first_w = WW'(run_first);
  assign owner_ok    = (9'(in_data.owner) < 9'(OWNERS));
  assign rd_more     = (rd_ptr_w < pages_w);
  assign out_free    = !out_valid_r || !out_stall;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    owner_nxt     = owner_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    chk_vld_nxt   = chk_vld_r;
    chk_ptr_nxt   = chk_ptr_r;
    run_nxt       = run_r;
    first_nxt     = first_r;
    wptr_nxt      = wptr_r;
    wleft_nxt     = wleft_r;
    wentry_nxt    = wentry_r;
    freed_nxt     = freed_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_addr       = rd_ptr_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = wptr_r;
    wr_entry      = wentry_r;

    unique case (state_r)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = S_IDLE;
        end
      end

      // decode a new command transaction
      S_IDLE: begin
        if (in_valid) begin
          owner_nxt             = in_data.owner;
          count_nxt             = in_cnt_w[CW-1:0];
          rd_ptr_nxt            = '0;
          chk_vld_nxt           = 1'b0;
          run_nxt               = '0;
          freed_nxt             = '0;
          res_nxt.status        = cpa_pkg::ST_FAIL;
          res_nxt.found_page    = '0;
          res_nxt.pages_changed = '0;
          priority if (!owner_ok) begin
            state_nxt = S_DONE;
          end else if (in_data.cmd == cpa_pkg::CMD_ALLOC) begin
            if (in_cnt_w == '0 || in_cnt_w > pages_w) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (in_data.cmd == cpa_pkg::CMD_RESERVE ||
                       in_data.cmd == cpa_pkg::CMD_FREE) begin
            if (in_end_w > pages_w) begin
              state_nxt = S_DONE;
            end else begin
              res_nxt.status        = cpa_pkg::ST_OK;
              res_nxt.pages_changed = in_data.page_count;
              wptr_nxt              = in_start_w[AW-1:0];
              wleft_nxt             = in_cnt_w[CW-1:0];
              if (in_data.cmd == cpa_pkg::CMD_RESERVE) begin
                wentry_nxt.reserved = 1'b1;
                wentry_nxt.owner    = in_data.owner;
              end else begin
                wentry_nxt = '0;
              end
              state_nxt = (in_cnt_w == '0) ? S_DONE : S_WRITE;
            end
          end else begin
            state_nxt = S_PURGE;
          end
        end
      end

      // first-fit scan, one entry checked per cycle behind the read
      S_SCAN: begin
        if (rd_more) begin
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_ptr_nxt = rd_ptr_r[AW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (!rd_entry.reserved) begin
            first_nxt = run_first;
            run_nxt   = run_r + 1'b1;
            if (run_w + 1'b1 == count_w) begin
              state_nxt             = S_WRITE;
              wptr_nxt              = run_first;
              wleft_nxt             = count_r;
              wentry_nxt.reserved   = 1'b1;
              wentry_nxt.owner      = owner_r;
              res_nxt.status        = cpa_pkg::ST_OK;
              res_nxt.found_page    = run_first_w[9:0];
              res_nxt.pages_changed = count_w[10:0];
            end
          end else begin
            run_nxt = '0;
          end
        end else if (!rd_more) begin
          state_nxt = S_DONE;
        end
      end

      // write one entry per cycle of a range
      S_WRITE: begin
        wr_en     = 1'b1;
        wptr_nxt  = wptr_r + 1'b1;
        wleft_nxt = wleft_r - 1'b1;
        if (wleft_r == CW'(1)) begin
          state_nxt = S_DONE;
        end
      end

      // free every page of the owner, write lags the read by one entry
      S_PURGE: begin
        if (rd_more) begin
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_ptr_nxt = rd_ptr_r[AW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (rd_entry.reserved && rd_entry.owner == owner_r) begin
            wr_en     = 1'b1;
            wr_addr   = chk_ptr_r;
            wr_entry  = '0;
            freed_nxt = freed_r + 1'b1;
          end
        end else if (!rd_more) begin
          res_nxt.status        = cpa_pkg::ST_OK;
          res_nxt.found_page    = '0;
          res_nxt.pages_changed = freed_w[10:0];
          state_nxt             = S_DONE;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    owner_r    <= owner_nxt;
    count_r    <= count_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    chk_ptr_r  <= chk_ptr_nxt;
    run_r      <= run_nxt;
    first_r    <= first_nxt;
    wptr_r     <= wptr_nxt;
    wleft_r    <= wleft_nxt;
    wentry_r   <= wentry_nxt;
    freed_r    <= freed_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/cpa_checker.sv =====
// cpa_checker: port-level checks of the contiguous page allocator
// bound to contiguous_page_allocator_unit; depends on cpa_pkg
module cpa_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input cpa_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cpa_pkg::out_t out_data
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // a failed command reports nothing found or changed
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == cpa_pkg::ST_FAIL |->
      out_data.found_page == '0 && out_data.pages_changed == '0)
    else $error("failed result carries a page or a count");

  // one command at a time: stall right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // reset starts the clearing pass with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block open right after reset");

endmodule

bind contiguous_page_allocator_unit cpa_checker u_cpa_checker (.*);
